/* rtl/dlgb_pkg.sv */
// shared constants and types for the degree-limited graph search block
package dlgb_pkg;
  localparam int MaxNodes = 32;
  localparam int MaxDegree = 4;
  localparam int NodeW = $clog2(MaxNodes);
  localparam int SlotW = $clog2(MaxDegree);
  localparam int TabW = NodeW + SlotW;
  localparam int CntW = $clog2(MaxDegree + 1);
  localparam int NcW = 6;

  localparam logic [1:0] ReqAdd = 2'd0;
  localparam logic [1:0] ReqFind = 2'd1;
  localparam logic [1:0] ReqClear = 2'd2;

  localparam logic [2:0] StOk = 3'd0;
  localparam logic [2:0] StSelf = 3'd1;
  localparam logic [2:0] StSrcFull = 3'd2;
  localparam logic [2:0] StDstFull = 3'd3;
  localparam logic [2:0] StDup = 3'd4;
  localparam logic [2:0] StRange = 3'd5;

  typedef logic [NodeW-1:0] node_t;
endpackage

/* rtl/dlgb_regs.sv */
// apb register file holding the node count
module dlgb_regs (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  output logic [dlgb_pkg::NcW-1:0] node_count
);
  import dlgb_pkg::*;
  localparam logic [0:0] RegNodeCount = 1'b0;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NcW'(MaxNodes);
    end else if (psel && penable && pwrite && paddr == RegNodeCount) begin
      node_count <= pwdata[NcW-1:0];
    end
  end
  assign prdata = (paddr == RegNodeCount) ? {{(32-NcW){1'b0}}, node_count} : 32'd0;
endmodule

/* rtl/degree_limited_graph_bfs_farthest.sv */
// breadth-first farthest-node search over a degree-limited graph
// add edge: result at once when a check fails, else after a duplicate scan of the source's
//   table entries and a write to both nodes' tables; clear and unknown requests: result at once
// query: visits every node reached from node 0, then scans the node count for the farthest,
//   its time set by one neighbour-table read port walked one entry at a time
// one item at a time, next item taken in the cycle the result beat is taken; sync reset empties graph
module degree_limited_graph_bfs_farthest (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] req_type,
  input  logic [4:0] node_a,
  input  logic [4:0] node_b,
  output logic out_valid,
  input  logic out_stall,
  output logic [2:0] status,
  output logic [4:0] farthest_node,
  output logic [4:0] farthest_distance,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import dlgb_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0, S_DUP = 4'd1, S_DUPW = 4'd2, S_WR = 4'd3,
    S_DEQ = 4'd4, S_RD = 4'd5, S_RDW = 4'd6, S_VISIT = 4'd7, S_SCAN = 4'd8, S_OUT = 4'd9;

  logic [NcW-1:0] node_count;
  dlgb_regs u_regs (.clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
    .pready, .node_count);

  logic [3:0] state;
  logic [CntW-1:0] ncount [MaxNodes];
  logic [NodeW-1:0] table_mem [MaxNodes*MaxDegree];
  logic [NodeW-1:0] rd_data;
  logic [TabW-1:0] rd_addr;
  logic [NodeW:0] nact;
  node_t a, b, cur;
  logic [MaxNodes-1:0] reached;
  logic [NodeW-1:0] hop_dist [MaxNodes];
  node_t queue [MaxNodes];
  logic [NodeW:0] head, tail, scan;
  logic [CntW-1:0] slot;
  logic wr_phase;
  logic [1:0] req;

  always_comb begin
    if (node_count == '0) nact = (NodeW+1)'(1);
    else if (node_count > NcW'(MaxNodes)) nact = (NodeW+1)'(MaxNodes);
    else nact = node_count[NodeW:0];
  end

  // a result beat still waiting holds off the next item
  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);

  // table memory: one write port, registered read
  logic tab_we;
  logic [TabW-1:0] tab_wa;
  node_t tab_wd;
  always_ff @(posedge clk) begin
    if (tab_we) table_mem[tab_wa] <= tab_wd;
    rd_data <= table_mem[rd_addr];
  end

  always_comb begin
    tab_we = 1'b0;
    tab_wa = {a, ncount[a][SlotW-1:0]};
    tab_wd = b;
    if (state == S_WR) begin
      tab_we = 1'b1;
      if (wr_phase) begin
        tab_wa = {b, ncount[b][SlotW-1:0]};
        tab_wd = a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      head <= '0;
      tail <= '0;
      for (int i = 0; i < MaxNodes; i++) ncount[i] <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (out_valid && !out_stall) out_valid <= 1'b0;
          if (in_valid && !in_stall) begin
            a <= node_a; b <= node_b; req <= req_type;
            status <= StOk; farthest_node <= '0; farthest_distance <= '0;
            slot <= '0;
            wr_phase <= 1'b0;
            case (req_type)
              ReqAdd: begin
                if ({1'b0, node_a} >= nact || {1'b0, node_b} >= nact) begin
                  status <= StRange; state <= S_OUT;
                end else if (node_a == node_b) begin
                  status <= StSelf; state <= S_OUT;
                end else if (ncount[node_a] >= CntW'(MaxDegree)) begin
                  status <= StSrcFull; state <= S_OUT;
                end else if (ncount[node_b] >= CntW'(MaxDegree)) begin
                  status <= StDstFull; state <= S_OUT;
                end else state <= S_DUP;
              end
              ReqFind: begin
                reached <= MaxNodes'(1);
                hop_dist[0] <= '0;
                queue[0] <= '0;
                head <= '0;
                tail <= (NodeW+1)'(1);
                state <= S_DEQ;
              end
              ReqClear: begin
                for (int i = 0; i < MaxNodes; i++) ncount[i] <= '0;
                state <= S_OUT;
              end
              default: state <= S_OUT;
            endcase
          end
        end
        S_DUP: begin
          if (slot >= ncount[a]) state <= S_WR;
          else begin
            rd_addr <= {a, slot[SlotW-1:0]};
            state <= S_DUPW;
          end
        end
        S_DUPW: begin
          state <= S_RD;
        end
        S_RD: begin
          // read data valid here for the duplicate scan; for the search it is valid in S_VISIT
          if (req == ReqAdd) begin
            if (rd_data == b) begin
              status <= StDup; state <= S_OUT;
            end else begin
              slot <= slot + 1'b1; state <= S_DUP;
            end
          end else state <= S_VISIT;
        end
        S_WR: begin
          if (!wr_phase) begin
            ncount[a] <= ncount[a] + 1'b1;
            wr_phase <= 1'b1;
          end else begin
            ncount[b] <= ncount[b] + 1'b1;
            state <= S_OUT;
          end
        end
        S_DEQ: begin
          if (head == tail) begin
            scan <= '0; state <= S_SCAN;
          end else begin
            cur <= queue[head[NodeW-1:0]];
            head <= head + 1'b1;
            slot <= '0;
            state <= S_RDW;
          end
        end
        S_RDW: begin
          if (slot >= ncount[cur]) state <= S_DEQ;
          else begin
            rd_addr <= {cur, slot[SlotW-1:0]};
            state <= S_RD;
          end
        end
        S_VISIT: begin
          if ({1'b0, rd_data} < nact && !reached[rd_data] &&
              tail < (NodeW+1)'(MaxNodes)) begin
            reached[rd_data] <= 1'b1;
            hop_dist[rd_data] <= hop_dist[cur] + 1'b1;
            queue[tail[NodeW-1:0]] <= rd_data;
            tail <= tail + 1'b1;
          end
          slot <= slot + 1'b1;
          state <= S_RDW;
        end
        S_SCAN: begin
          if (scan >= nact) state <= S_OUT;
          else begin
            if (reached[scan[NodeW-1:0]] &&
                hop_dist[scan[NodeW-1:0]] > farthest_distance) begin
              farthest_distance <= hop_dist[scan[NodeW-1:0]];
              farthest_node <= scan[NodeW-1:0];
            end
            scan <= scan + 1'b1;
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  property p_busy_no_out;
    @(posedge clk) disable iff (rst) (state != S_IDLE && state != S_OUT) |-> in_stall;
  endproperty
  a_busy: assert property (p_busy_no_out) else $error("accepted while busy");
  a_tail: assert property (@(posedge clk) disable iff (rst)
    tail <= (NodeW+1)'(MaxNodes)) else $error("queue overflow");
  a_head: assert property (@(posedge clk) disable iff (rst)
    (state == S_DEQ) |-> head <= tail) else $error("queue underflow");
  a_deg: assert property (@(posedge clk) disable iff (rst)
    (state == S_WR) |-> ncount[a] < CntW'(MaxDegree) || wr_phase)
    else $error("degree overrun");
endmodule
